FILE: rtl/xcfb_pkg.sv
// Shared types and constants for the XOR-checked frame builder.
// No dependencies; imported by every module of the block.
package xcfb_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 1'b1;

    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'd256;
    localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'hAA;

    // Item opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME  = 2'd2;

    // All results caused by one input item
    typedef struct packed {
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
        logic [STATUS_W-1:0]                status;
        logic [CNT_W-1:0]                   count;
    } burst_t;

endpackage

FILE: rtl/xor_checked_frame_builder.sv
// XOR-checked byte framer: header, payload pass-through, trailing checksum.
// Burst registered on the item's transfer; each result then in the m_* register.
// Throughput: one result per cycle while m_ready is high; an item with n results
// (1..5) holds the burst register to its last, so payload streams one item/cycle.
// Reset (aresetn, synchronous, active low): no frame open, checksum cleared,
// max_payload = 256, start_byte = 0xAA, both channels empty.
module xor_checked_frame_builder (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [xcfb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [xcfb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [xcfb_pkg::BYTE_W-1:0]      s_msg_type,
    input  logic [xcfb_pkg::LEN_W-1:0]       s_payload_length,
    input  logic [xcfb_pkg::BYTE_W-1:0]      s_data_byte,
    // results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [xcfb_pkg::BYTE_W-1:0]      m_tx_byte,
    output logic [xcfb_pkg::STATUS_W-1:0]    m_status,
    output logic                             m_last_of_run
);
    import xcfb_pkg::*;

    burst_t burst;
    logic   item_accept;

    // State advances on the input transfer; the decoded burst is captured
    // by the serializer in the same edge.
    assign item_accept = s_valid && s_ready;

    xcfb_framer u_framer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .item_accept    (item_accept),
        .opcode         (s_opcode),
        .msg_type       (s_msg_type),
        .payload_length (s_payload_length),
        .data_byte      (s_data_byte),
        .burst          (burst)
    );

    // Burst register plus output register: the next item is taken on the edge
    // that loads the last result of the current one into the m_ side register.
    xcfb_serializer u_serializer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_burst      (burst),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run)
    );

endmodule

FILE: rtl/xcfb_framer.sv
// Frame state, configuration registers and per-item result decode.
// Depends on xcfb_pkg.
module xcfb_framer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [xcfb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [xcfb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             item_accept,
    input  logic                             opcode,
    input  logic [xcfb_pkg::BYTE_W-1:0]      msg_type,
    input  logic [xcfb_pkg::LEN_W-1:0]       payload_length,
    input  logic [xcfb_pkg::BYTE_W-1:0]      data_byte,
    output xcfb_pkg::burst_t                 burst
);
    import xcfb_pkg::*;

    logic [LEN_W-1:0]  max_payload_reg;
    logic [BYTE_W-1:0] start_byte_reg;
    logic              frame_open_reg, frame_open_next;
    logic [LEN_W-1:0]  bytes_remaining_reg, bytes_remaining_next;
    logic [BYTE_W-1:0] running_xor_reg, running_xor_next;

    logic [BYTE_W-1:0] len_lo, len_hi, hdr_xor, data_xor;
    logic [LEN_W-1:0]  rem_dec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RST;
            start_byte_reg  <= START_BYTE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_wdata;
                REG_START_BYTE:  start_byte_reg  <= cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_lo   = payload_length[BYTE_W-1:0];
    assign len_hi   = payload_length[LEN_W-1:BYTE_W];
    assign hdr_xor  = msg_type ^ len_lo ^ len_hi;
    assign data_xor = running_xor_reg ^ data_byte;
    assign rem_dec  = bytes_remaining_reg - LEN_W'(1);

    always_comb begin
        burst                = '0;
        burst.status         = ST_OK;
        burst.count          = CNT_W'(1);
        frame_open_next      = frame_open_reg;
        bytes_remaining_next = bytes_remaining_reg;
        running_xor_next     = running_xor_reg;
        case (opcode)
            OP_START: begin
                if (payload_length > max_payload_reg) begin
                    burst.status         = ST_TOO_LARGE;
                    frame_open_next      = 1'b0;
                    bytes_remaining_next = '0;
                    running_xor_next     = '0;
                end else begin
                    burst.bytes[0]       = start_byte_reg;
                    burst.bytes[1]       = msg_type;
                    burst.bytes[2]       = len_lo;
                    burst.bytes[3]       = len_hi;
                    burst.bytes[4]       = hdr_xor;
                    // zero length: checksum follows the header at once
                    burst.count          = (payload_length == '0) ? CNT_W'(5) : CNT_W'(4);
                    running_xor_next     = hdr_xor;
                    frame_open_next      = (payload_length != '0);
                    bytes_remaining_next = payload_length;
                end
            end
            OP_DATA: begin
                if (!frame_open_reg) begin
                    burst.status = ST_NO_FRAME;
                end else begin
                    burst.bytes[0]       = data_byte;
                    burst.bytes[1]       = data_xor;
                    running_xor_next     = data_xor;
                    bytes_remaining_next = rem_dec;
                    if (rem_dec == '0) begin
                        burst.count     = CNT_W'(2);
                        frame_open_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg      <= 1'b0;
            bytes_remaining_reg <= '0;
            running_xor_reg     <= '0;
        end else if (item_accept) begin
            frame_open_reg      <= frame_open_next;
            bytes_remaining_reg <= bytes_remaining_next;
            running_xor_reg     <= running_xor_next;
        end
    end

`ifndef SYNTHESIS
    a_open_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_open_reg |-> (bytes_remaining_reg != '0))
        else $error("frame open with no bytes remaining");

    a_error_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_accept && burst.status == ST_TOO_LARGE) |=> !frame_open_reg)
        else $error("oversize start left a frame open");
`endif

endmodule

FILE: rtl/xcfb_serializer.sv
// Burst holding register and output register: emits one result per transfer.
// Depends on xcfb_pkg.
module xcfb_serializer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  xcfb_pkg::burst_t                in_burst,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [xcfb_pkg::BYTE_W-1:0]     m_tx_byte,
    output logic [xcfb_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_last_of_run
);
    import xcfb_pkg::*;

    burst_t            burst_reg;
    logic              burst_valid_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] tx_byte_reg;
    logic [STATUS_W-1:0] status_reg;
    logic              last_reg;

    logic out_load, last_elem, in_accept;

    assign out_load  = burst_valid_reg && (!out_valid_reg || m_ready);
    assign last_elem = (idx_reg == burst_reg.count - CNT_W'(1));
    assign in_ready  = !burst_valid_reg || (out_load && last_elem);
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_valid_reg <= 1'b0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (in_accept) begin
                burst_valid_reg <= 1'b1;
                idx_reg         <= '0;
            end else if (out_load) begin
                burst_valid_reg <= !last_elem;
                idx_reg         <= last_elem ? '0 : idx_reg + CNT_W'(1);
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            burst_reg <= in_burst;
        end
        if (out_load) begin
            tx_byte_reg <= burst_reg.bytes[idx_reg];
            status_reg  <= burst_reg.status;
            last_reg    <= last_elem;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_tx_byte     = tx_byte_reg;
    assign m_status      = status_reg;
    assign m_last_of_run = last_reg;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_valid_reg |-> (idx_reg < burst_reg.count))
        else $error("burst index past result count");

    a_burst_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !last_elem) |=> (burst_valid_reg && idx_reg == $past(idx_reg) + CNT_W'(1)))
        else $error("burst dropped before its last result");
`endif

endmodule
